@@ sv/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Time of day of one item, as it leaves the clock-field pipeline.
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    // Calendar fields of one item, as they leave the date pipeline.
    typedef struct packed {
        logic [2:0] weekday;
        logic [7:0] years;
        logic [8:0] yday;
        logic [3:0] month;
        logic [4:0] mday;
    } t_date;

    // Seconds in a day divided by 128, and the matching reciprocal (2^35 / 675).
    localparam logic [9:0]  QuarterDay = 10'd675;
    localparam logic [25:0] RecipDay   = 26'd50903316;

    // Seconds in an hour divided by 16, reciprocal 2^21 / 225.
    localparam logic [7:0]  HourUnit  = 8'd225;
    localparam logic [13:0] RecipHour = 14'd9320;

    // Seconds in a minute divided by 4, reciprocal 2^10 / 15.
    localparam logic [3:0]  MinUnit  = 4'd15;
    localparam logic [6:0]  RecipMin = 7'd68;

    // Weekday: day zero is a Thursday; reciprocal 2^16 / 7.
    localparam logic [2:0]  DaysPerWeek  = 3'd7;
    localparam logic [2:0]  EpochWeekday = 3'd4;
    localparam logic [13:0] RecipWeek    = 14'd9362;

    // Era arithmetic, counted from 1600-03-01 in 400-year eras.
    localparam logic [17:0] EraDays     = 18'd146097;
    localparam logic [17:0] EraLastDay  = 18'd146096;
    localparam logic [17:0] EpochToEra  = 18'd135080;
    localparam logic [10:0] DaysPer4Yr  = 11'd1460;
    localparam logic [7:0]  Recip4Yr    = 8'd179;
    localparam logic [17:0] DaysPer100  = 18'd36524;
    localparam logic [8:0]  DaysPerYear = 9'd365;
    localparam logic [9:0]  RecipYear   = 10'd718;

    // March-based year: January and February close it.
    localparam logic [3:0]  JanMp       = 4'd10;
    localparam logic [8:0]  MarchToJan  = 9'd306;
    localparam logic [8:0]  JanFebDays  = 9'd59;
    localparam logic [8:0]  Era1Offset  = 9'd100;
    localparam logic [8:0]  Era0Offset  = 9'd300;

    // Stage counts of the two parallel pipelines and the padding between them.
    localparam int HmsStages   = 6;
    localparam int DateStages  = 10;
    localparam int AlignDepth  = DateStages - HmsStages;

    // First day of each month within a year that starts on 1 March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/epoch_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into time of day, weekday and Gregorian date.
// ----------------------------------------------------------------------------
// A new item may be started in every clock cycle, so busy never rises; its
// result appears on the o_ ports, marked by o_valid for one cycle, after it
// has passed the split and date pipelines: three stages split off the day
// count, then ten stages of reciprocal multiplications and single-step
// corrections find the year, month and day, while the time of day waits in
// a short delay line beside them. Results cannot be held off, so the
// receiver must take each one in the cycle it is shown.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [7:0]  o_years_since_1900,
    output logic [8:0]  o_day_of_year,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_of_month
);

    logic                           split_valid;
    logic [15:0]                    split_days;
    logic [16:0]                    split_tod;
    logic                           hms_valid;
    esc_pkg::t_hms                  hms;
    logic                           date_valid;
    esc_pkg::t_date                 date;
    logic [esc_pkg::AlignDepth-1:0] r_hval;
    esc_pkg::t_hms                  r_hdly [esc_pkg::AlignDepth];

    assign busy = 1'b0;

    esc_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_secs  (i_epoch_seconds),
        .o_valid (split_valid),
        .o_days  (split_days),
        .o_tod   (split_tod)
    );

    esc_hms u_hms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .i_tod   (split_tod),
        .o_valid (hms_valid),
        .o_hms   (hms)
    );

    esc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .i_days  (split_days),
        .o_valid (date_valid),
        .o_date  (date)
    );

    // The time of day is ready before the date; hold it back to line up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hval <= '0;
        end else begin
            r_hval <= {r_hval[esc_pkg::AlignDepth-2:0], hms_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdly[0] <= hms;
        for (int i = 1; i < esc_pkg::AlignDepth; i++) begin
            r_hdly[i] <= r_hdly[i-1];
        end
    end

    assign o_valid            = date_valid;
    assign o_second           = r_hdly[esc_pkg::AlignDepth-1].second;
    assign o_minute           = r_hdly[esc_pkg::AlignDepth-1].minute;
    assign o_hour             = r_hdly[esc_pkg::AlignDepth-1].hour;
    assign o_weekday          = date.weekday;
    assign o_years_since_1900 = date.years;
    assign o_day_of_year      = date.yday;
    assign o_month_index      = date.month;
    assign o_day_of_month     = date.mday;

    a_paths_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hval[esc_pkg::AlignDepth-1] == date_valid)
        else $error("time-of-day and date items are out of step");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##13 o_valid)
        else $error("started item did not produce a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 13))
        else $error("result without a started item");

    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60)
                    && (o_weekday < 3'd7))
        else $error("time-of-day field out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_index < 4'd12) && (o_day_of_month != 5'd0)
                    && (o_day_of_year < 9'd366) && (o_years_since_1900 >= 8'd70))
        else $error("calendar field out of range");

endmodule

@@ sv/esc_split.sv @@
// ----------------------------------------------------------------------------
// esc_split
// Splits a seconds count into whole days and seconds of the day (3 stages).
// ----------------------------------------------------------------------------
module esc_split (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_secs,
    output logic        o_valid,
    output logic [15:0] o_days,
    output logic [16:0] o_tod
);

    logic [2:0]  r_valid;
    logic [50:0] r1_prod;
    logic [24:0] r1_x;
    logic [6:0]  r1_lo;
    logic [15:0] r2_q;
    logic [10:0] r2_rem;
    logic [6:0]  r2_lo;
    logic [15:0] r3_days;
    logic [16:0] r3_tod;

    logic [50:0] n1_prod;
    logic [15:0] n2_q;
    logic [24:0] n2_back;
    logic [10:0] n2_rem;
    logic        n3_fix;
    logic [15:0] n3_days;
    logic [9:0]  n3_rem;

    // The low seven bits are a factor of 86400 = 128 * 675, so only the upper
    // part goes through the reciprocal.
    assign n1_prod = 51'(i_secs[31:7]) * 51'(esc_pkg::RecipDay);

    // The estimate is exact or one short; the remainder shows which.
    assign n2_q    = r1_prod[50:35];
    assign n2_back = 25'(n2_q) * 25'(esc_pkg::QuarterDay);
    assign n2_rem  = 11'(r1_x - n2_back);

    assign n3_fix  = r2_rem >= 11'(esc_pkg::QuarterDay);
    assign n3_days = r2_q + 16'(n3_fix);
    assign n3_rem  = 10'(n3_fix ? r2_rem - 11'(esc_pkg::QuarterDay) : r2_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod <= n1_prod;
        r1_x    <= i_secs[31:7];
        r1_lo   <= i_secs[6:0];
        r2_q    <= n2_q;
        r2_rem  <= n2_rem;
        r2_lo   <= r1_lo;
        r3_days <= n3_days;
        r3_tod  <= {n3_rem, r2_lo};
    end

    assign o_valid = r_valid[2];
    assign o_days  = r3_days;
    assign o_tod   = r3_tod;

endmodule

@@ sv/esc_hms.sv @@
// ----------------------------------------------------------------------------
// esc_hms
// Breaks seconds of the day into hour, minute and second (6 stages).
// ----------------------------------------------------------------------------
module esc_hms (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [16:0]   i_tod,
    output logic          o_valid,
    output esc_pkg::t_hms o_hms
);

    logic [5:0]    r_valid;
    logic [26:0]   r1_prod;
    logic [12:0]   r1_y;
    logic [3:0]    r1_lo;
    logic [5:0]    r2_h;
    logic [8:0]    r2_rem;
    logic [3:0]    r2_lo;
    logic [4:0]    r3_hour;
    logic [11:0]   r3_rs;
    logic [16:0]   r4_prod;
    logic [9:0]    r4_z;
    logic [1:0]    r4_lo;
    logic [4:0]    r4_hour;
    logic [6:0]    r5_m;
    logic [4:0]    r5_rem;
    logic [1:0]    r5_lo;
    logic [4:0]    r5_hour;
    esc_pkg::t_hms r6_hms;

    logic [26:0]   n1_prod;
    logic [5:0]    n2_h;
    logic [12:0]   n2_back;
    logic [8:0]    n2_rem;
    logic          n3_fix;
    logic [4:0]    n3_hour;
    logic [7:0]    n3_rem;
    logic [16:0]   n4_prod;
    logic [6:0]    n5_m;
    logic [9:0]    n5_back;
    logic [4:0]    n5_rem;
    logic          n6_fix;
    esc_pkg::t_hms n6_hms;

    // Hours: 3600 = 16 * 225.
    assign n1_prod = 27'(i_tod[16:4]) * 27'(esc_pkg::RecipHour);

    assign n2_h    = r1_prod[26:21];
    assign n2_back = 13'(n2_h) * 13'(esc_pkg::HourUnit);
    assign n2_rem  = 9'(r1_y - n2_back);

    assign n3_fix  = r2_rem >= 9'(esc_pkg::HourUnit);
    assign n3_hour = 5'(r2_h + 6'(n3_fix));
    assign n3_rem  = 8'(n3_fix ? r2_rem - 9'(esc_pkg::HourUnit) : r2_rem);

    // Minutes: 60 = 4 * 15.
    assign n4_prod = 17'(r3_rs[11:2]) * 17'(esc_pkg::RecipMin);

    assign n5_m    = r4_prod[16:10];
    assign n5_back = 10'(n5_m) * 10'(esc_pkg::MinUnit);
    assign n5_rem  = 5'(r4_z - n5_back);

    assign n6_fix         = r5_rem >= 5'(esc_pkg::MinUnit);
    assign n6_hms.hour    = r5_hour;
    assign n6_hms.minute  = 6'(r5_m + 7'(n6_fix));
    assign n6_hms.second  = {4'(n6_fix ? r5_rem - 5'(esc_pkg::MinUnit) : r5_rem), r5_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod <= n1_prod;
        r1_y    <= i_tod[16:4];
        r1_lo   <= i_tod[3:0];
        r2_h    <= n2_h;
        r2_rem  <= n2_rem;
        r2_lo   <= r1_lo;
        r3_hour <= n3_hour;
        r3_rs   <= {n3_rem, r2_lo};
        r4_prod <= n4_prod;
        r4_z    <= r3_rs[11:2];
        r4_lo   <= r3_rs[1:0];
        r4_hour <= r3_hour;
        r5_m    <= n5_m;
        r5_rem  <= n5_rem;
        r5_lo   <= r4_lo;
        r5_hour <= r4_hour;
        r6_hms  <= n6_hms;
    end

    assign o_valid = r_valid[5];
    assign o_hms   = r6_hms;

endmodule

@@ sv/esc_date.sv @@
// ----------------------------------------------------------------------------
// esc_date
// Turns a day count since 1970-01-01 into weekday, year, day of year, month
// and day of month (10 stages), using 400-year eras from 1600-03-01.
// ----------------------------------------------------------------------------
module esc_date (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [15:0]    i_days,
    output logic           o_valid,
    output esc_pkg::t_date o_date
);

    logic [9:0]     r_valid;

    logic [15:0]    r1_w;
    logic [28:0]    r1_wp;
    logic [17:0]    r1_doe;
    logic           r1_era;

    logic [3:0]     r2_wr;
    logic [17:0]    r2_doe;
    logic           r2_era;
    logic [2:0]     r2_c;
    logic           r2_f;
    logic [24:0]    r2_a;

    logic [2:0]     r3_wday;
    logic [17:0]    r3_doe;
    logic           r3_era;
    logic [2:0]     r3_c;
    logic           r3_f;
    logic [6:0]     r3_k;
    logic [11:0]    r3_rk;

    logic [2:0]     r4_wday;
    logic [17:0]    r4_doe;
    logic           r4_era;
    logic [17:0]    r4_n;

    logic [2:0]     r5_wday;
    logic [17:0]    r5_doe;
    logic           r5_era;
    logic [17:0]    r5_n;
    logic [26:0]    r5_yp;

    logic [2:0]     r6_wday;
    logic [17:0]    r6_doe;
    logic           r6_era;
    logic [8:0]     r6_y;
    logic [9:0]     r6_ry;

    logic [2:0]     r7_wday;
    logic [17:0]    r7_doe;
    logic           r7_era;
    logic [8:0]     r7_yoe;

    logic [2:0]     r8_wday;
    logic           r8_era;
    logic [8:0]     r8_yoe;
    logic [8:0]     r8_doy;

    logic [2:0]     r9_wday;
    logic           r9_era;
    logic [8:0]     r9_yoe;
    logic [8:0]     r9_doy;
    logic [3:0]     r9_mp;
    logic           r9_leap;

    esc_pkg::t_date r10_date;

    logic [15:0]    n1_w;
    logic [28:0]    n1_wp;
    logic [17:0]    n1_e;
    logic           n1_era;
    logic [17:0]    n1_doe;
    logic [12:0]    n2_wq;
    logic [3:0]     n2_wr;
    logic [2:0]     n2_c;
    logic [24:0]    n2_a;
    logic [2:0]     n3_wday;
    logic [6:0]     n3_k;
    logic [11:0]    n3_rk;
    logic [17:0]    n4_n;
    logic [26:0]    n5_yp;
    logic [8:0]     n6_y;
    logic [9:0]     n6_ry;
    logic [8:0]     n7_yoe;
    logic [1:0]     n8_cent;
    logic [17:0]    n8_base;
    logic [8:0]     n8_doy;
    logic [3:0]     n9_mp;
    logic           n9_leap;
    logic           n10_janfeb;
    logic [8:0]     n10_ys;
    esc_pkg::t_date n10_date;

    // Stage 1: weekday reciprocal, and the day count placed in its era.
    assign n1_w   = i_days + 16'(esc_pkg::EpochWeekday);
    assign n1_wp  = 29'(n1_w) * 29'(esc_pkg::RecipWeek);
    assign n1_e   = 18'(i_days) + esc_pkg::EpochToEra;
    assign n1_era = n1_e >= esc_pkg::EraDays;
    assign n1_doe = n1_era ? n1_e - esc_pkg::EraDays : n1_e;

    // Stage 2: weekday remainder; leap-day corrections within the era.
    assign n2_wq = r1_wp[28:16];
    assign n2_wr = 4'(r1_w - 16'(n2_wq) * 16'(esc_pkg::DaysPerWeek));
    assign n2_c  = 3'(r1_doe >= esc_pkg::DaysPer100)
                 + 3'(r1_doe >= 18'(2 * esc_pkg::DaysPer100))
                 + 3'(r1_doe >= 18'(3 * esc_pkg::DaysPer100))
                 + 3'(r1_doe >= esc_pkg::EraLastDay);
    assign n2_a  = 25'(r1_doe) * 25'(esc_pkg::Recip4Yr);

    // Stage 3.
    assign n3_wday = 3'(r2_wr >= 4'(esc_pkg::DaysPerWeek)
                        ? r2_wr - 4'(esc_pkg::DaysPerWeek) : r2_wr);
    assign n3_k    = r2_a[24:18];
    assign n3_rk   = 12'(r2_doe - 18'(n3_k) * 18'(esc_pkg::DaysPer4Yr));

    // Stage 4: the day count with leap days removed, so that it divides by 365.
    assign n4_n = r3_doe - 18'(r3_k) - 18'(r3_rk >= 12'(esc_pkg::DaysPer4Yr))
                + 18'(r3_c) - 18'(r3_f);

    // Stages 5 to 7: year of era.
    assign n5_yp  = 27'(r4_n) * 27'(esc_pkg::RecipYear);
    assign n6_y   = r5_yp[26:18];
    assign n6_ry  = 10'(r5_n - 18'(n6_y) * 18'(esc_pkg::DaysPerYear));
    assign n7_yoe = r6_y + 9'(r6_ry >= 10'(esc_pkg::DaysPerYear));

    // Stage 8: day of the March-based year.
    assign n8_cent = 2'(r7_yoe >= 9'd100) + 2'(r7_yoe >= 9'd200) + 2'(r7_yoe >= 9'd300);
    assign n8_base = 18'(r7_yoe) * 18'(esc_pkg::DaysPerYear) + 18'(r7_yoe[8:2])
                   - 18'(n8_cent);
    assign n8_doy  = 9'(r7_doe - n8_base);

    // Stage 9: month from the March-based month starts.
    always_comb begin
        n9_mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r8_doy >= esc_pkg::month_start(4'(i))) begin
                n9_mp = n9_mp + 4'd1;
            end
        end
    end

    // A century year inside the era is common, but the era's first year is leap.
    assign n9_leap = (r8_yoe[1:0] == 2'd0) && (r8_yoe != 9'd100)
                   && (r8_yoe != 9'd200) && (r8_yoe != 9'd300);

    // Stage 10: January and February belong to the next calendar year.
    assign n10_janfeb = r9_mp >= esc_pkg::JanMp;
    assign n10_ys     = (r9_era ? r9_yoe + esc_pkg::Era1Offset : r9_yoe - esc_pkg::Era0Offset)
                      + 9'(n10_janfeb);

    assign n10_date.weekday = r9_wday;
    assign n10_date.years   = n10_ys[7:0];
    assign n10_date.yday    = n10_janfeb ? r9_doy - esc_pkg::MarchToJan
                                         : r9_doy + esc_pkg::JanFebDays + 9'(r9_leap);
    assign n10_date.month   = n10_janfeb ? r9_mp - esc_pkg::JanMp : r9_mp + 4'd2;
    assign n10_date.mday    = 5'(r9_doy - esc_pkg::month_start(r9_mp) + 9'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[8:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_w     <= n1_w;
        r1_wp    <= n1_wp;
        r1_doe   <= n1_doe;
        r1_era   <= n1_era;

        r2_wr    <= n2_wr;
        r2_doe   <= r1_doe;
        r2_era   <= r1_era;
        r2_c     <= n2_c;
        r2_f     <= r1_doe == esc_pkg::EraLastDay;
        r2_a     <= n2_a;

        r3_wday  <= n3_wday;
        r3_doe   <= r2_doe;
        r3_era   <= r2_era;
        r3_c     <= r2_c;
        r3_f     <= r2_f;
        r3_k     <= n3_k;
        r3_rk    <= n3_rk;

        r4_wday  <= r3_wday;
        r4_doe   <= r3_doe;
        r4_era   <= r3_era;
        r4_n     <= n4_n;

        r5_wday  <= r4_wday;
        r5_doe   <= r4_doe;
        r5_era   <= r4_era;
        r5_n     <= r4_n;
        r5_yp    <= n5_yp;

        r6_wday  <= r5_wday;
        r6_doe   <= r5_doe;
        r6_era   <= r5_era;
        r6_y     <= n6_y;
        r6_ry    <= n6_ry;

        r7_wday  <= r6_wday;
        r7_doe   <= r6_doe;
        r7_era   <= r6_era;
        r7_yoe   <= n7_yoe;

        r8_wday  <= r7_wday;
        r8_era   <= r7_era;
        r8_yoe   <= r7_yoe;
        r8_doy   <= n8_doy;

        r9_wday  <= r8_wday;
        r9_era   <= r8_era;
        r9_yoe   <= r8_yoe;
        r9_doy   <= r8_doy;
        r9_mp    <= n9_mp;
        r9_leap  <= n9_leap;

        r10_date <= n10_date;
    end

    assign o_valid = r_valid[9];
    assign o_date  = r10_date;

endmodule

@@ verif/epoch_seconds_to_calendar_test.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test
// Self-checking bench for the seconds-to-calendar converter. A short table of
// calendar corner cases is followed by random counts. These cover year and
// month boundaries, the top of the 32-bit range, small counts and single-bit
// patterns. Every result is checked field by field against a behavioural
// calendar predictor, or against the result typed into the table row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_test;

    localparam int QuietLimit     = 5000;
    localparam int DrainCycles    = 20;
    localparam int ItemsPerPhase  = 170;
    localparam int SecondsPerDay  = 86400;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } t_calendar;

    // One row of the directed table: a count, and its result where typed in.
    typedef struct packed {
        logic [31:0] secs;
        logic        has_literal;
        t_calendar   cal;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_epoch_seconds;
    logic        o_valid;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [2:0]  o_weekday;
    logic [7:0]  o_years_since_1900;
    logic [8:0]  o_day_of_year;
    logic [3:0]  o_month_index;
    logic [4:0]  o_day_of_month;

    t_calendar cal_expected[$];
    t_calendar next_cal;
    t_stim_row directed_rows[$];
    int        errors = 0;
    int        quiet_cycles = 0;

    epoch_seconds_to_calendar DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .o_second           (o_second),
        .o_minute           (o_minute),
        .o_hour             (o_hour),
        .o_weekday          (o_weekday),
        .o_years_since_1900 (o_years_since_1900),
        .o_day_of_year      (o_day_of_year),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned year_days(input int unsigned year);
        if ((year % 100) == 0) begin
            return ((year % 400) == 0) ? 366 : 365;
        end
        return ((year % 4) == 0) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned month,
                                                  input int unsigned year);
        case (month)
            1:             return (year_days(year) == 366) ? 29 : 28;
            3, 5, 8, 10:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic t_calendar calendar_of(input logic [31:0] secs);
        t_calendar   r;
        logic [31:0] t;
        logic [31:0] days;
        int unsigned year;
        int unsigned month;
        r.second = 6'(secs % 60);
        t        = secs / 60;
        r.minute = 6'(t % 60);
        t        = t / 60;
        r.hour   = 5'(t % 24);
        days     = t / 24;
        // The first day of the epoch was a Thursday.
        r.weekday = 3'((days + 4) % 7);
        year = 1970;
        while (days >= year_days(year)) begin
            days = days - year_days(year);
            year++;
        end
        r.years_since_1900 = 8'(year - 1900);
        r.day_of_year      = 9'(days);
        month = 0;
        while (month < 11 && days >= days_in_month(month, year)) begin
            days = days - days_in_month(month, year);
            month++;
        end
        r.month_index  = 4'(month);
        r.day_of_month = 5'(days + 1);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Holds one item on the inputs until it is taken, after an optional idle.
    task automatic send_calendar_item(input logic [31:0] secs, input t_calendar cal,
                                      input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_epoch_seconds <= secs;
        next_cal         = cal;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results;
        start <= 1'b0;
        while (cal_expected.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : watch_results
        t_calendar seen;
        t_calendar want;
        logic      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                cal_expected.push_back(next_cal);
                moved = 1'b1;
            end
            if ($isunknown(o_valid)) begin
                $display("%0t: result strobe expected 0 or 1, got %b", $time, o_valid);
                errors++;
            end else if (o_valid) begin
                moved = 1'b1;
                seen  = {o_second, o_minute, o_hour, o_weekday, o_years_since_1900,
                         o_day_of_year, o_month_index, o_day_of_month};
                if (cal_expected.size() == 0) begin
                    $display("%0t: expected no result, got %h", $time, seen);
                    errors++;
                end else begin
                    want = cal_expected.pop_front();
                    check_field("second", 9'(want.second), 9'(seen.second));
                    check_field("minute", 9'(want.minute), 9'(seen.minute));
                    check_field("hour", 9'(want.hour), 9'(seen.hour));
                    check_field("weekday", 9'(want.weekday), 9'(seen.weekday));
                    check_field("years_since_1900", 9'(want.years_since_1900),
                                9'(seen.years_since_1900));
                    check_field("day_of_year", want.day_of_year, seen.day_of_year);
                    check_field("month_index", 9'(want.month_index),
                                9'(seen.month_index));
                    check_field("day_of_month", 9'(want.day_of_month),
                                9'(seen.day_of_month));
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QuietLimit) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        t_stim_row   row;
        logic [31:0] secs;
        longint      s;
        int          off;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int          kind;
        int          idle_pct;
        int          k;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_epoch_seconds = '0;
        next_cal        = '0;

        // The epoch itself, its last second of the first day, and the top count.
        directed_rows.push_back({32'd0, 1'b1,
            6'd0, 6'd0, 5'd0, 3'd4, 8'd70, 9'd0, 4'd0, 5'd1});
        directed_rows.push_back({32'd86399, 1'b1,
            6'd59, 6'd59, 5'd23, 3'd4, 8'd70, 9'd0, 4'd0, 5'd1});
        directed_rows.push_back({32'hFFFF_FFFF, 1'b1,
            6'd15, 6'd28, 5'd6, 3'd0, 8'd206, 9'd37, 4'd1, 5'd7});
        directed_rows.push_back({32'd86400, 1'b0, 46'd0});
        directed_rows.push_back({32'd31535999, 1'b0, 46'd0});   // 1970-12-31 23:59:59
        directed_rows.push_back({32'd31536000, 1'b0, 46'd0});
        directed_rows.push_back({32'd68169600, 1'b0, 46'd0});   // 1972-02-29
        directed_rows.push_back({32'd68256000, 1'b0, 46'd0});
        directed_rows.push_back({32'd946684799, 1'b0, 46'd0});
        directed_rows.push_back({32'd951782400, 1'b0, 46'd0});  // 2000-02-29
        directed_rows.push_back({32'd951868800, 1'b0, 46'd0});
        directed_rows.push_back({32'd978307199, 1'b0, 46'd0});  // last day of a leap year
        directed_rows.push_back({32'd2147483647, 1'b0, 46'd0});
        directed_rows.push_back({32'd2147483648, 1'b0, 46'd0});
        directed_rows.push_back({32'd4102444799, 1'b0, 46'd0});
        directed_rows.push_back({32'd4107542399, 1'b0, 46'd0}); // 2100 has no 29 February
        directed_rows.push_back({32'd4107542400, 1'b0, 46'd0});
        directed_rows.push_back({32'd4291747199, 1'b0, 46'd0});
        directed_rows.push_back({32'd4291747200, 1'b0, 46'd0});
        directed_rows.push_back({32'hAAAA_AAAA, 1'b0, 46'd0});
        directed_rows.push_back({32'h5555_5555, 1'b0, 46'd0});

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_calendar_item(row.secs, row.has_literal ? row.cal : calendar_of(row.secs), 10);
        end

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 10 : (phase == 1) ? 71 : 0;
            if (phase != 0) begin
                wait_for_results();
            end
            for (int n = 0; n < ItemsPerPhase; n++) begin
                kind = $urandom_range(99);
                if (kind < 40) begin
                    secs = $urandom;
                end else if (kind < 75) begin
                    // Near the start of a month, often within a few seconds of it.
                    y = $urandom_range(2106, 1970);
                    m = $urandom_range(11, 0);
                    d = 0;
                    for (k = 1970; k < y; k++) d += year_days(k);
                    for (k = 0; k < m; k++) d += days_in_month(k, y);
                    off  = $urandom_range(1) ? int'($urandom_range(4)) - 2
                                             : int'($urandom_range(172800)) - SecondsPerDay;
                    s    = longint'(d) * SecondsPerDay + off;
                    secs = s[31:0];
                end else if (kind < 85) begin
                    secs = 32'hFFFF_FFFF - $urandom_range(4000000);
                end else if (kind < 95) begin
                    secs = $urandom_range(400000);
                end else begin
                    k    = $urandom_range(31);
                    secs = $urandom_range(1) ? (32'd1 << k) : ~(32'd1 << k);
                end
                send_calendar_item(secs, calendar_of(secs), idle_pct);
            end
        end

        wait_for_results();
        repeat (DrainCycles) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
